// ----- hw/rtl/sbpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted bound priority queue package
// Shared sizes, codes and transfer types for the queue and its cells.
// ----------------------------------------------------------------------------
package sbpq_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 16;
  localparam int KEY_W       = 32;
  localparam int IO_TAG_W    = 16;
  localparam int COUNT_W     = 7;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Requested action of one input transfer.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PRUNE  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Completion status of one step.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Data movement ordered along the row of cells.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    action_t                    action;
    logic signed [KEY_W-1:0]    key;
    logic        [IO_TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic                       head_valid;
    logic signed [KEY_W-1:0]    head_key;
    logic        [IO_TAG_W-1:0] head_tag;
    logic        [COUNT_W-1:0]  count;
    status_t                    status;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic signed [KEY_W-1:0]    key;
    logic        [TAG_BITS-1:0] tag;
  } entry_t;

  // Broadcast to every cell: the movement and the key/tag that go with it.
  typedef struct packed {
    cell_op_t                   op;
    logic signed [KEY_W-1:0]    key;
    logic        [TAG_BITS-1:0] tag;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/sbpq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted bound priority queue cell
// Holds one entry, compares it with the broadcast key and moves data to or
// from its neighbours.
// ----------------------------------------------------------------------------
module sbpq_cell (
  input  logic               clk,
  input  sbpq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               le_left_i,
  input  sbpq_pkg::entry_t   left_i,
  input  sbpq_pkg::entry_t   right_i,
  output sbpq_pkg::entry_t   entry_o,
  output logic               le_o
);

  sbpq_pkg::entry_t entry_r;
  sbpq_pkg::entry_t entry_nxt;
  logic             le;

  // The cell is at or before the insert point when it holds a key not above
  // the broadcast key; the same flag marks entries kept by a prune.
  assign le = occ_i && ($signed(entry_r.key) <= $signed(ctrl_i.key));

  // Keep, take the new entry at the insert point, or shift along the row.
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl_i.op)
      sbpq_pkg::OP_INSERT: begin
        if (!le) begin
          if (le_left_i) begin
            entry_nxt.key = ctrl_i.key;
            entry_nxt.tag = ctrl_i.tag;
          end else begin
            entry_nxt = left_i;
          end
        end
      end
      sbpq_pkg::OP_POP: begin
        entry_nxt = right_i;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // Entry storage carries no reset; occupancy comes from the fill count.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign le_o    = le;

endmodule

// ----- hw/rtl/sorted_bound_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// Sorted bound priority queue
// Bounded queue of branch-and-bound nodes in ascending key order, built as a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Busy is always low, so a new command may be issued on every cycle. The
// result of a command accepted at a clock edge is presented, with out_strobe
// high, during the following cycle only; the receiver cannot stall and must
// take it then. Insert, pop and prune each act on all cells at once, with one
// key comparator per cell, so the rate does not depend on how many entries
// are held. Entry storage is not cleared at reset; only the fill count,
// status and result strobe are.
module sorted_bound_priority_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sbpq_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output sbpq_pkg::out_item_t out_item
);

  localparam int DEPTH = sbpq_pkg::QUEUE_DEPTH;
  localparam int CW    = sbpq_pkg::CNT_W;

  logic                 accept;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        prune_cnt;
  sbpq_pkg::status_t    status_r;
  sbpq_pkg::status_t    status_nxt;
  logic                 out_strobe_r;
  sbpq_pkg::cell_ctrl_t ctrl;
  sbpq_pkg::entry_t     entries [DEPTH];
  logic [DEPTH:0]       le;

  // The block never holds off a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the command into a cell movement, the new fill count and status.
  always_comb begin
    ctrl.op    = sbpq_pkg::OP_HOLD;
    ctrl.key   = in_item.key;
    ctrl.tag   = sbpq_pkg::TAG_BITS'(in_item.tag);
    count_nxt  = count_r;
    status_nxt = sbpq_pkg::ST_DONE;
    if (accept) begin
      case (in_item.action)
        sbpq_pkg::ACT_INSERT: begin
          if (count_r >= CW'(DEPTH)) begin
            status_nxt = sbpq_pkg::ST_FULL;
          end else begin
            ctrl.op   = sbpq_pkg::OP_INSERT;
            count_nxt = CW'(count_r + 1'b1);
          end
        end
        sbpq_pkg::ACT_POP: begin
          if (count_r == '0) begin
            status_nxt = sbpq_pkg::ST_EMPTY;
          end else begin
            ctrl.op   = sbpq_pkg::OP_POP;
            count_nxt = CW'(count_r - 1'b1);
          end
        end
        sbpq_pkg::ACT_PRUNE: begin
          count_nxt = prune_cnt;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Row of cells; cell zero always sees an insert point to its left.
  assign le[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             occ;
    logic             le_left;
    sbpq_pkg::entry_t left_entry;
    sbpq_pkg::entry_t right_entry;

    assign occ = count_r > CW'(i);

    if (i == 0) begin : g_first
      assign le_left    = 1'b1;
      assign left_entry = entries[i];
    end else begin : g_mid
      assign le_left    = le[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sbpq_cell u_cell (
      .clk       (clk),
      .ctrl_i    (ctrl),
      .occ_i     (occ),
      .le_left_i (le_left),
      .left_i    (left_entry),
      .right_i   (right_entry),
      .entry_o   (entries[i]),
      .le_o      (le[i])
    );
  end

  // Kept entries form a prefix; the last kept cell gives the new count.
  always_comb begin
    prune_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (le[i] && !le[i+1]) begin
        prune_cnt = prune_cnt | CW'(i + 1);
      end
    end
  end

  // Fill count, status and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      status_r     <= sbpq_pkg::ST_DONE;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      status_r     <= status_nxt;
      out_strobe_r <= accept;
    end
  end

  // Result transfer: the front cell and the count as they stand after the step.
  always_comb begin
    out_item.head_valid = count_r != '0;
    out_item.head_key   = '0;
    out_item.head_tag   = '0;
    if (count_r != '0) begin
      out_item.head_key = entries[0].key;
      out_item.head_tag = sbpq_pkg::IO_TAG_W'(entries[0].tag);
    end
    out_item.count  = sbpq_pkg::COUNT_W'(count_r);
    out_item.status = status_r;
  end

  assign out_strobe = out_strobe_r;

endmodule
